// File: hdl/urn_pkg.sv
// urn_pkg: shared constants and types for the urn sampler
// opcodes of the input word and default sizes of the count stores
// no dependencies
package urn_pkg;

    localparam int MAX_COLORS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;
    localparam int READ_LIMIT     = 16;
    localparam int COLORS_RST     = 16;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_DRAW = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } opcode_t;

endpackage

// File: hdl/urn_sampler_without_replacement_top.sv
// urn sampler without replacement: count and tally stores, sequencer, adders, multiplier and a compare
// depends on urn_pkg
//
// load: written in the idle state, no result. draw with n colors in use: the count store
// is walked once to sum and once to pick, through its single read port.
// read: one tally word per color, one color per pass through the read port.
// the block takes one input word at a time and is not ready while an item is in work.
// reset (synchronous, active low) marks all colors empty with zero tallies, colors_in_use 16.
module urn_sampler_without_replacement_top #(
    parameter int MAX_COLORS = urn_pkg::MAX_COLORS_DEF,
    parameter int COUNT_BITS = urn_pkg::COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    // input words
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [3:0]  s_color_index,
    input  logic [15:0] s_ball_count,
    input  logic [31:0] s_random_fraction,
    // result words
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_color,
    output logic [15:0] m_tally,
    output logic        m_urn_empty,
    output logic        m_last
);
    import urn_pkg::*;

    localparam int CIDX  = $clog2(MAX_COLORS);
    localparam int TOT_W = COUNT_BITS + CIDX;
    localparam int EXT_W = (TOT_W > 32) ? TOT_W : 33;
    localparam int HI_W  = EXT_W - 32;
    localparam int PW    = 32 + HI_W + 1;
    localparam int COLW  = (CIDX > 4) ? CIDX : 4;
    localparam int TW    = (COUNT_BITS > 16) ? COUNT_BITS : 16;

    typedef enum logic [9:0] {
        ST_IDLE     = 10'b0000000001,
        ST_SUM      = 10'b0000000010,
        ST_SUM_DONE = 10'b0000000100,
        ST_MUL      = 10'b0000001000,
        ST_MUL2     = 10'b0000010000,
        ST_WALK     = 10'b0000100000,
        ST_UPDATE   = 10'b0001000000,
        ST_EMPTY    = 10'b0010000000,
        ST_RD_ADDR  = 10'b0100000000,
        ST_RD_OUT   = 10'b1000000000
    } state_t;

    // stores
    logic [COUNT_BITS-1:0] balls_mem [MAX_COLORS];
    logic [COUNT_BITS-1:0] tally_mem [MAX_COLORS];
    logic [MAX_COLORS-1:0] valid_reg, valid_next;

    // control
    state_t          state_reg, state_next;
    logic [CIDX-1:0] idx_reg, idx_next;
    logic [CIDX-1:0] last_idx_reg, last_idx_next;
    logic [4:0]      colors_reg;
    logic            rd_en_reg;
    logic            m_valid_reg, m_valid_next;

    // datapath
    logic [COUNT_BITS-1:0] rd_cnt_q, rd_tal_q;
    logic                  rd_vld_q;
    logic [CIDX-1:0]       rd_idx_reg;
    logic [31:0]           u_reg;
    logic [TOT_W-1:0]      sum_reg, run_reg, target_reg;
    logic [63:0]           prod_lo_reg;
    logic [CIDX-1:0]       chosen_idx_reg;
    logic [COUNT_BITS-1:0] chosen_cnt_reg, chosen_tal_reg;

    logic [3:0]  m_color_reg;
    logic [15:0] m_tally_reg;
    logic        m_empty_reg, m_last_reg;

    logic [COUNT_BITS-1:0] cnt_eff, tal_eff, tally_inc;
    logic [TOT_W-1:0]      run_sum;
    logic [EXT_W-1:0]      tot_ext;
    logic [PW-1:0]         tsum;
    logic                  out_free, out_load, walk_hit;
    logic                  mem_we;
    logic [CIDX-1:0]       mem_waddr;
    logic [COUNT_BITS-1:0] mem_wcnt, mem_wtal;
    logic [CIDX-1:0]       res_idx;
    logic [COUNT_BITS-1:0] res_tally;
    logic                  res_empty, res_last;
    logic [COLW-1:0]       color_ext;
    logic [TW-1:0]         tally_ext;
    logic [6:0]            act;
    logic                  load_in_range;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;

    assign cnt_eff   = rd_vld_q ? rd_cnt_q : '0;
    assign tal_eff   = rd_vld_q ? rd_tal_q : '0;
    assign tally_inc = (chosen_tal_reg == '1) ? chosen_tal_reg : chosen_tal_reg + 1'b1;
    assign run_sum   = run_reg + TOT_W'(cnt_eff);
    assign walk_hit  = rd_en_reg && (target_reg < run_sum);
    assign tot_ext   = EXT_W'(sum_reg);
    // floor(u * total / 2^32) from the low partial product and the narrow high part
    assign tsum      = PW'(prod_lo_reg[63:32]) + PW'(u_reg) * PW'(tot_ext[EXT_W-1:32]);
    assign load_in_range = (32'(s_color_index) < 32'(MAX_COLORS));

    // colors taking part, clamped to 1..MAX_COLORS, and to READ_LIMIT for a read
    always_comb begin
        if (colors_reg == '0) begin
            act = 7'd1;
        end else if (32'(colors_reg) > 32'(MAX_COLORS)) begin
            act = 7'(MAX_COLORS);
        end else begin
            act = 7'(colors_reg);
        end
        if (opcode_t'(s_opcode) == OP_READ && 32'(act) > 32'(READ_LIMIT)) begin
            act = 7'(READ_LIMIT);
        end
    end

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        out_load      = 1'b0;
        res_idx       = idx_reg;
        res_tally     = '0;
        res_empty     = 1'b0;
        res_last      = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = chosen_idx_reg;
        mem_wcnt      = chosen_cnt_reg - 1'b1;
        mem_wtal      = tally_inc;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    idx_next      = '0;
                    last_idx_next = CIDX'(act - 7'd1);
                    case (opcode_t'(s_opcode))
                        OP_LOAD: begin
                            if (load_in_range) begin
                                mem_we    = 1'b1;
                                mem_waddr = CIDX'(s_color_index);
                                mem_wcnt  = COUNT_BITS'(s_ball_count);
                                mem_wtal  = '0;
                            end
                        end
                        OP_DRAW: state_next = ST_SUM;
                        OP_READ: state_next = ST_RD_ADDR;
                        default: ;
                    endcase
                end
            end
            ST_SUM: begin
                if (idx_reg == last_idx_reg) begin
                    state_next = ST_SUM_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_SUM_DONE: state_next = ST_MUL;
            ST_MUL: begin
                state_next = (sum_reg == '0) ? ST_EMPTY : ST_MUL2;
            end
            ST_MUL2: begin
                idx_next   = '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (idx_reg != last_idx_reg) begin
                    idx_next = idx_reg + 1'b1;
                end
                if (walk_hit) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (out_free) begin
                    mem_we       = 1'b1;
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    res_idx      = chosen_idx_reg;
                    res_tally    = tally_inc;
                    res_last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    res_idx      = '0;
                    res_empty    = 1'b1;
                    res_last     = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD_ADDR: state_next = ST_RD_OUT;
            ST_RD_OUT: begin
                if (out_free) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    res_tally    = tal_eff;
                    res_last     = (idx_reg == last_idx_reg);
                    if (idx_reg == last_idx_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD_ADDR;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        if (mem_we) begin
            valid_next[mem_waddr] = 1'b1;
        end
    end

    assign color_ext = COLW'(res_idx);
    assign tally_ext = TW'(res_tally);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            last_idx_reg <= '0;
            colors_reg   <= 5'(COLORS_RST);
            valid_reg    <= '0;
            rd_en_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            last_idx_reg <= last_idx_next;
            valid_reg    <= valid_next;
            rd_en_reg    <= (state_reg == ST_SUM) || (state_reg == ST_WALK);
            m_valid_reg  <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                colors_reg <= cfg_data;
            end
        end
    end

    // count and tally stores, one read address and one write address
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            balls_mem[mem_waddr] <= mem_wcnt;
            tally_mem[mem_waddr] <= mem_wtal;
        end
        rd_cnt_q   <= balls_mem[idx_reg];
        rd_tal_q   <= tally_mem[idx_reg];
        rd_vld_q   <= valid_reg[idx_reg];
        rd_idx_reg <= idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            u_reg <= s_random_fraction;
        end
        if (state_reg == ST_IDLE) begin
            sum_reg <= '0;
        end else if (rd_en_reg && (state_reg == ST_SUM || state_reg == ST_SUM_DONE)) begin
            sum_reg <= sum_reg + TOT_W'(cnt_eff);
        end
        if (state_reg == ST_MUL) begin
            prod_lo_reg <= 64'(u_reg) * 64'(tot_ext[31:0]);
        end
        if (state_reg == ST_MUL2) begin
            target_reg <= TOT_W'(tsum);
            run_reg    <= '0;
        end else if (state_reg == ST_WALK && rd_en_reg && !walk_hit) begin
            run_reg <= run_sum;
        end
        if (state_reg == ST_WALK && walk_hit) begin
            chosen_idx_reg <= rd_idx_reg;
            chosen_cnt_reg <= cnt_eff;
            chosen_tal_reg <= tal_eff;
        end
        if (out_load) begin
            m_color_reg <= color_ext[3:0];
            m_tally_reg <= tally_ext[15:0];
            m_empty_reg <= res_empty;
            m_last_reg  <= res_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_color     = m_color_reg;
    assign m_tally     = m_tally_reg;
    assign m_urn_empty = m_empty_reg;
    assign m_last      = m_last_reg;

    // the walk never passes the scaled target before it picks a color
    a_walk_below_target: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> run_reg <= target_reg)
        else $error("walk running sum passed target");

    a_walk_needs_balls: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_WALK |-> sum_reg != '0)
        else $error("walk started on empty urn");

    a_pick_has_ball: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE |-> chosen_cnt_reg != '0)
        else $error("picked color holds no balls");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_urn_empty |-> m_last && m_color == 4'd0 && m_tally == 16'd0)
        else $error("empty-urn word malformed");

    a_busy_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK || state_reg == ST_SUM) |-> !s_ready)
        else $error("input taken during draw");

endmodule

// File: tb/tb_urn_sampler_without_replacement_top.sv
// testbench for urn_sampler_without_replacement_top: directed table, then random phases
// keeps a shadow urn that predicts the result words (typed table rows give their own) and checks them field by field
// depends on urn_pkg and the rtl top level
module tb_urn_sampler_without_replacement_top;

    timeunit 1ns;
    timeprecision 1ps;

    import urn_pkg::*;

    localparam int NUM_COLORS = MAX_COLORS_DEF;
    localparam int SCRIPT_ROWS = 23;
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 40;
    localparam int SETTLE_CYCLES = 48;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [3:0]  color;
        logic [15:0] tally;
        logic        urn_empty;
        logic        last;
    } tally_word_t;

    typedef struct {
        opcode_t     op;
        logic [3:0]  idx;
        logic [15:0] cnt;
        logic [31:0] frac;
        bit          typed;
        tally_word_t want;
    } urn_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_opcode = OP_NONE;
    logic [3:0]  s_color_index = '0;
    logic [15:0] s_ball_count = '0;
    logic [31:0] s_random_fraction = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [3:0]  m_color;
    logic [15:0] m_tally;
    logic        m_urn_empty;
    logic        m_last;

    // shadow copy of the urn
    logic [15:0] shadow_balls [NUM_COLORS];
    logic [15:0] shadow_tally [NUM_COLORS];
    logic [4:0]  shadow_colors = 5'd16;

    tally_word_t owed_words [$];
    tally_word_t new_words [$];
    tally_word_t got_word;
    urn_row_t    script [SCRIPT_ROWS];
    int          fails = 0;
    int          cycles = 0;
    int          ready_hold = 0;

    urn_sampler_without_replacement_top u_top (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_opcode          (s_opcode),
        .s_color_index     (s_color_index),
        .s_ball_count      (s_ball_count),
        .s_random_fraction (s_random_fraction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_color           (m_color),
        .m_tally           (m_tally),
        .m_urn_empty       (m_urn_empty),
        .m_last            (m_last)
    );

    always #5 aclk = ~aclk;

    function automatic int colors_active();
        if (shadow_colors == 5'd0) begin
            return 1;
        end
        if (int'(shadow_colors) > NUM_COLORS) begin
            return NUM_COLORS;
        end
        return int'(shadow_colors);
    endfunction

    // updates the shadow urn and leaves the words this item causes in new_words
    task automatic apply_to_shadow_urn(input urn_row_t r);
        int          n;
        int          m;
        int          c;
        logic [63:0] in_use;
        logic [63:0] target;
        logic [63:0] run;
        tally_word_t w;
        begin
            n = colors_active();
            new_words.delete();
            case (r.op)
                OP_LOAD: begin
                    if (int'(r.idx) < NUM_COLORS) begin
                        shadow_balls[r.idx] = r.cnt;
                        shadow_tally[r.idx] = '0;
                    end
                end
                OP_DRAW: begin
                    in_use = '0;
                    for (c = 0; c < n; c++) in_use += 64'(shadow_balls[c]);
                    if (in_use == 0) begin
                        w = '{color: 4'd0, tally: 16'd0, urn_empty: 1'b1, last: 1'b1};
                    end else begin
                        target = (64'(r.frac) * in_use) >> 32;
                        run = '0;
                        for (c = 0; c < n; c++) begin
                            run += 64'(shadow_balls[c]);
                            if (target < run) break;
                        end
                        if (c >= n) c = n - 1;
                        shadow_balls[c] = shadow_balls[c] - 16'd1;
                        if (shadow_tally[c] != 16'hFFFF) shadow_tally[c] = shadow_tally[c] + 16'd1;
                        w = '{color: 4'(c), tally: shadow_tally[c], urn_empty: 1'b0, last: 1'b1};
                    end
                    new_words.push_back(w);
                end
                OP_READ: begin
                    m = (n < READ_LIMIT) ? n : READ_LIMIT;
                    for (c = 0; c < m; c++) begin
                        w = '{color: 4'(c), tally: shadow_tally[c], urn_empty: 1'b0,
                              last: (c == m - 1)};
                        new_words.push_back(w);
                    end
                end
                default: begin
                end
            endcase
        end
    endtask

    function automatic urn_row_t mk_row(opcode_t op, logic [3:0] idx, logic [15:0] cnt,
                                        logic [31:0] frac, bit typed, logic [3:0] color,
                                        logic [15:0] tally, logic empty);
        urn_row_t r;
        r.op = op;
        r.idx = idx;
        r.cnt = cnt;
        r.frac = frac;
        r.typed = typed;
        r.want = '{color: color, tally: tally, urn_empty: empty, last: 1'b1};
        return r;
    endfunction

    // holds the word until accepted; a zero gap keeps valid high back to back
    task automatic post_item(input urn_row_t r, input int gap);
        begin
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_opcode <= r.op;
            s_color_index <= r.idx;
            s_ball_count <= r.cnt;
            s_random_fraction <= r.frac;
            do @(posedge aclk); while (!s_ready);
            apply_to_shadow_urn(r);
            if (r.typed) begin
                owed_words.push_back(r.want);
            end else begin
                foreach (new_words[k]) owed_words.push_back(new_words[k]);
            end
        end
    endtask

    // stop sending, let every owed word come back, then give loads time to finish
    task automatic drain_urn();
        begin
            s_valid <= 1'b0;
            while (owed_words.size() != 0) @(posedge aclk);
            repeat (SETTLE_CYCLES) @(posedge aclk);
        end
    endtask

    task automatic set_colors_in_use(input logic [4:0] value);
        begin
            cfg_valid <= 1'b1;
            cfg_data <= value;
            do @(posedge aclk); while (!cfg_ready);
            shadow_colors = value;
            cfg_valid <= 1'b0;
        end
    endtask

    function automatic int pick_gap(bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic urn_row_t random_row();
        urn_row_t r;
        int       pick;
        int       sz;
        r = mk_row(OP_NONE, 4'($urandom), 16'($urandom), $urandom, 1'b0, '0, '0, 1'b0);
        pick = $urandom_range(0, 99);
        if (pick < 22) begin
            r.op = OP_LOAD;
            if ($urandom_range(0, 9) < 7) r.idx = 4'($urandom_range(0, colors_active() - 1));
            sz = $urandom_range(0, 9);
            // mostly small counts so the urn runs dry now and then
            if (sz < 6) r.cnt = 16'($urandom_range(0, 12));
            else if (sz < 8) r.cnt = 16'($urandom_range(0, 300));
            else if (sz == 9) r.cnt = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else if (pick < 80) begin
            r.op = OP_DRAW;
            sz = $urandom_range(0, 9);
            if (sz == 0) r.frac = 32'h0000_0000;
            else if (sz == 1) r.frac = 32'hFFFF_FFFF;
        end else if (pick < 94) begin
            r.op = OP_READ;
        end
        return r;
    endfunction

    // receiver stalls: runs of ready, mostly short stalls, a few long ones
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            ready_hold <= 0;
        end else if (ready_hold == 0) begin
            if ($urandom_range(0, 1) == 1) begin
                m_ready <= 1'b1;
                ready_hold <= $urandom_range(1, 40);
            end else begin
                m_ready <= 1'b0;
                ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_words.size() == 0) begin
                $error("result word with none owed: color %0d tally %0d", m_color, m_tally);
                fails++;
            end else begin
                got_word = owed_words.pop_front();
                if (m_color !== got_word.color) begin
                    $error("color: expected %0d, got %0d", got_word.color, m_color);
                    fails++;
                end
                if (m_tally !== got_word.tally) begin
                    $error("tally: expected %0d, got %0d", got_word.tally, m_tally);
                    fails++;
                end
                if (m_urn_empty !== got_word.urn_empty) begin
                    $error("urn_empty: expected %0b, got %0b", got_word.urn_empty, m_urn_empty);
                    fails++;
                end
                if (m_last !== got_word.last) begin
                    $error("last: expected %0b, got %0b", got_word.last, m_last);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        int       i;
        int       p;
        int       sent;
        logic [4:0] cv;
        urn_row_t r;

        for (i = 0; i < NUM_COLORS; i++) begin
            shadow_balls[i] = '0;
            shadow_tally[i] = '0;
        end

        script[0]  = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h0000_0000, 1'b1, 4'd0, 16'd0, 1'b1);
        script[1]  = mk_row(OP_READ, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[2]  = mk_row(OP_NONE, 4'hF,  16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        script[3]  = mk_row(OP_LOAD, 4'd15, 16'hFFFF, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[4]  = mk_row(OP_LOAD, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[5]  = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h0000_0000, 1'b1, 4'd15, 16'd1, 1'b0);
        script[6]  = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'hFFFF_FFFF, 1'b1, 4'd15, 16'd2, 1'b0);
        script[7]  = mk_row(OP_LOAD, 4'd3,  16'd1,    32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[8]  = mk_row(OP_LOAD, 4'd7,  16'd2,    32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[9]  = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h0000_0000, 1'b1, 4'd3, 16'd1, 1'b0);
        script[10] = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h0000_0000, 1'b1, 4'd7, 16'd1, 1'b0);
        script[11] = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h8000_0000, 1'b0, '0, '0, 1'b0);
        script[12] = mk_row(OP_READ, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[13] = mk_row(OP_LOAD, 4'd15, 16'h0000, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        // a single ball left in color 7, the top fraction still lands on it
        script[14] = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'hFFFF_FFFF, 1'b1, 4'd7, 16'd2, 1'b0);
        script[15] = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h0000_0000, 1'b1, 4'd0, 16'd0, 1'b1);
        script[16] = mk_row(OP_NONE, 4'hF,  16'hFFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        script[17] = mk_row(OP_LOAD, 4'd10, 16'hAAAA, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[18] = mk_row(OP_LOAD, 4'd5,  16'h5555, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[19] = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h1234_5678, 1'b0, '0, '0, 1'b0);
        script[20] = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'hFFFF_FFFF, 1'b0, '0, '0, 1'b0);
        script[21] = mk_row(OP_DRAW, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, '0, '0, 1'b0);
        script[22] = mk_row(OP_READ, 4'd0,  16'h0000, 32'h0000_0000, 1'b0, '0, '0, 1'b0);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < SCRIPT_ROWS; i++) post_item(script[i], pick_gap(1'b0));
        drain_urn();

        for (p = 0; p < PHASES; p++) begin
            // raw extremes first, then the effective ones, then a few in between
            case (p)
                0: cv = 5'd0;
                1: cv = 5'd31;
                2: cv = 5'd1;
                3: cv = 5'd16;
                4: cv = 5'd17;
                7: cv = 5'd5;
                default: cv = 5'($urandom_range(2, 15));
            endcase
            set_colors_in_use(cv);
            sent = 0;
            while (sent < ITEMS_PER_PHASE) begin
                r = random_row();
                post_item(r, pick_gap(p % 3 == 1));
                if (r.op != OP_NONE) sent++;
            end
            drain_urn();
        end

        if (fails == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
